@@ hw/rtl/shdf_pkg.sv @@
// ----------------------------------------------------------------------------
// shdf_pkg
// Shared types, constants and the sync matcher step for the deframer.
// ----------------------------------------------------------------------------
package shdf_pkg;

   // Sync word AA 55 AA 55, first byte at index 0
   localparam int unsigned SYNC_LEN = 4;
   localparam logic [3:0][7:0] SYNC_WORD = {8'h55, 8'hAA, 8'h55, 8'hAA};
   // Fallback table for a partial match (entry k: length kept after k+1 bytes)
   localparam logic [3:0][1:0] SYNC_FAIL = {2'd2, 2'd1, 2'd0, 2'd0};

   // Header store geometry and fixed header field positions
   localparam int unsigned STORE_DEPTH = 16;
   localparam int unsigned IDX_W       = 4;
   localparam int unsigned TYPE_FIRST  = 4;
   localparam int unsigned TYPE_CHARS  = 5;
   localparam int unsigned LEN_FIRST   = 12;

   localparam int unsigned LEN_W = 24;
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd550000;

   // Result queue between classifier and output side
   localparam int unsigned QUEUE_DEPTH = 4;

   // Configuration register indexes
   localparam logic REG_MAX_PAYLOAD = 1'b0;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef struct packed {
      logic        last;
      logic [39:0] frame_type;
      logic [7:0]  payload_byte;
      kind_type    kind;
   } result_type;

   // One byte through the sync matcher; returns the new matched count (0..4)
   function automatic logic [2:0] sync_advance(input logic [2:0] s_in, input logic [7:0] b);
      logic [2:0] s;
      s = s_in;
      if (s >= 3'(SYNC_LEN)) begin
         s = {1'b0, SYNC_FAIL[SYNC_LEN-1]};
      end
      for (int i = 0; i < 3; i++) begin
         if (s != 3'd0 && b != SYNC_WORD[s[1:0]]) begin
            s = {1'b0, SYNC_FAIL[s[1:0] - 2'd1]};
         end
      end
      if (b == SYNC_WORD[s[1:0]]) begin
         s = s + 3'd1;
      end
      return s;
   endfunction

endpackage

@@ hw/rtl/shdf_queue.sv @@
// ----------------------------------------------------------------------------
// shdf_queue
// Short result queue; its head drives the result channel directly.
// ----------------------------------------------------------------------------
module shdf_queue #(
   parameter int unsigned WIDTH = 51,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/shdf_front.sv @@
// ----------------------------------------------------------------------------
// shdf_front
// Byte classifier: sync hunt, header collection and checks, payload tagging,
// and the replay of buffered header bytes after a rejected header.
// ----------------------------------------------------------------------------
module shdf_front #(
   parameter int unsigned HEADER_BYTES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [7:0]                     in_byte,
   input  logic [shdf_pkg::LEN_W-1:0]     max_payload,
   input  logic                           queue_full,
   output logic                           push,
   output shdf_pkg::result_type           push_data
);

   localparam int unsigned LEN_W = shdf_pkg::LEN_W;
   localparam int unsigned IDX_W = shdf_pkg::IDX_W;
   localparam int unsigned DEPTH = shdf_pkg::STORE_DEPTH;
   localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0] HDR_LAST = LEN_W'(HEADER_BYTES - 1);
   localparam logic [IDX_W-1:0] REPLAY_LAST = IDX_W'(HEADER_BYTES - 1);

   shdf_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          sync_ff, sync_in;
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [LEN_W-1:0]    plen_ff, plen_in;
   logic [39:0]         ftype_ff, ftype_in;
   logic                replay_ff, replay_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;
   logic [7:0]          store_ff [DEPTH];
   logic [7:0]          store_in [DEPTH];

   logic                step_en;
   logic [7:0]          step_byte;
   logic [IDX_W-1:0]    wr_idx;
   logic [7:0]          hdr_view [DEPTH];
   logic [39:0]         hdr_type;
   logic [LEN_W-1:0]    total;
   logic [LEN_W-1:0]    payload_len;
   logic                hdr_ok;
   logic [2:0]          sync_next;
   logic                pay_last;

   // input is held off while the header bytes are replayed
   assign in_ready  = !replay_ff && !queue_full;
   assign step_en   = replay_ff || (in_valid && in_ready);
   assign step_byte = replay_ff ? store_ff[ridx_ff] : in_byte;
   assign wr_idx    = count_ff[IDX_W-1:0];

   // header as it stands once the current byte is written
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         hdr_view[k] = (wr_idx == IDX_W'(k)) ? step_byte : store_ff[k];
      end
      for (int c = 0; c < shdf_pkg::TYPE_CHARS; c++) begin
         hdr_type[8*c +: 8] = hdr_view[shdf_pkg::TYPE_FIRST + c];
      end
      total = {hdr_view[shdf_pkg::LEN_FIRST + 2], hdr_view[shdf_pkg::LEN_FIRST + 1],
               hdr_view[shdf_pkg::LEN_FIRST]};
   end

   assign payload_len = total - HDR_LEN;
   assign hdr_ok      = (total >= HDR_LEN) && (payload_len <= max_payload);
   assign sync_next   = shdf_pkg::sync_advance(sync_ff, step_byte);
   assign pay_last    = ((count_ff + 1'b1) >= plen_ff);

   // step of the framing state machine
   always_comb begin
      phase_in  = phase_ff;
      sync_in   = sync_ff;
      count_in  = count_ff;
      plen_in   = plen_ff;
      ftype_in  = ftype_ff;
      replay_in = replay_ff;
      ridx_in   = ridx_ff;
      store_in  = store_ff;
      push      = 1'b0;
      push_data = '0;

      if (replay_ff) begin
         if (ridx_ff == REPLAY_LAST) begin
            replay_in = 1'b0;
         end else begin
            ridx_in = ridx_ff + 1'b1;
         end
      end

      if (step_en) begin
         case (phase_ff)
            shdf_pkg::PH_HEADER: begin
               store_in[wr_idx] = step_byte;
               count_in         = count_ff + 1'b1;
               if (count_ff == HDR_LAST) begin
                  ftype_in             = hdr_type;
                  push                 = 1'b1;
                  push_data.frame_type = hdr_type;
                  count_in             = '0;
                  sync_in              = '0;
                  if (!hdr_ok) begin
                     // rescan bytes 1 onwards for another sync word
                     push_data.kind = shdf_pkg::KIND_REJECT;
                     phase_in       = shdf_pkg::PH_HUNT;
                     replay_in      = 1'b1;
                     ridx_in        = IDX_W'(1);
                  end else if (payload_len == '0) begin
                     push_data.kind = shdf_pkg::KIND_EMPTY;
                     push_data.last = 1'b1;
                     phase_in       = shdf_pkg::PH_HUNT;
                  end else begin
                     push     = 1'b0;
                     plen_in  = payload_len;
                     phase_in = shdf_pkg::PH_PAYLOAD;
                  end
               end
            end
            shdf_pkg::PH_PAYLOAD: begin
               push                   = 1'b1;
               push_data.kind         = shdf_pkg::KIND_PAYLOAD;
               push_data.payload_byte = step_byte;
               push_data.frame_type   = ftype_ff;
               push_data.last         = pay_last;
               if (pay_last) begin
                  phase_in = shdf_pkg::PH_HUNT;
                  count_in = '0;
                  sync_in  = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               // hunting; the unused phase code behaves the same
               phase_in = shdf_pkg::PH_HUNT;
               sync_in  = sync_next;
               if (sync_next == 3'(shdf_pkg::SYNC_LEN)) begin
                  for (int k = 0; k < shdf_pkg::SYNC_LEN; k++) begin
                     store_in[k] = shdf_pkg::SYNC_WORD[k];
                  end
                  count_in = LEN_W'(shdf_pkg::SYNC_LEN);
                  sync_in  = '0;
                  phase_in = shdf_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= shdf_pkg::PH_HUNT;
         sync_ff   <= '0;
         count_ff  <= '0;
         plen_ff   <= '0;
         ftype_ff  <= '0;
         replay_ff <= 1'b0;
         ridx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         sync_ff   <= sync_in;
         count_ff  <= count_in;
         plen_ff   <= plen_in;
         ftype_ff  <= ftype_in;
         replay_ff <= replay_in;
         ridx_ff   <= ridx_in;
      end
   end

   // header store, undefined until written
   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

@@ hw/rtl/sync_header_length_deframer_core.sv @@
// ----------------------------------------------------------------------------
// sync_header_length_deframer_core
// Byte-serial deframer for a sync-word, length-prefixed packet stream.
//
//   port group | dir | transfer carries
//   req_*      | in  | one received byte
//   rsp_*      | out | payload byte / empty frame / header reject, with type
//   csr_*      | in  | max_payload_bytes register (byte address 0)
//
// One byte per cycle is taken while no replay runs and the queue has room;
// results reach rsp_* from the head of the result queue. A rejected header
// holds req_tready low while its stored bytes replay through the sync matcher.
// A four-entry result queue lets the output stall without blocking input
// until it fills. Reset is synchronous; max_payload_bytes returns to 550000.
// ----------------------------------------------------------------------------
module sync_header_length_deframer_core #(
   parameter int unsigned HEADER_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] payload_byte, [47:8] frame_type
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // frame_last
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned LEN_W = shdf_pkg::LEN_W;
   localparam int unsigned RES_W = $bits(shdf_pkg::result_type);

   logic [LEN_W-1:0]     max_payload_ff, max_payload_in;
   logic                 csr_wr;
   logic                 queue_full;
   logic                 push;
   shdf_pkg::result_type push_data;
   shdf_pkg::result_type head;
   logic [RES_W-1:0]     head_bits;

   // register port: always ready, write on the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == shdf_pkg::REG_MAX_PAYLOAD);
   assign csr_prdata = (csr_paddr[2] == shdf_pkg::REG_MAX_PAYLOAD)
                       ? {8'b0, max_payload_ff} : 32'b0;

   always_comb begin
      max_payload_in = max_payload_ff;
      if (csr_wr) begin
         max_payload_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= shdf_pkg::MAX_PAYLOAD_RESET;
      end else begin
         max_payload_ff <= max_payload_in;
      end
   end

   // classifier
   shdf_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .max_payload (max_payload_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // result queue feeding the output channel
   shdf_queue #(
      .WIDTH (RES_W),
      .DEPTH (shdf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head_bits)
   );

   assign head      = shdf_pkg::result_type'(head_bits);
   assign rsp_tdata = {head.frame_type, head.payload_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
